FILE: hdl/keyed_quantity_table_macros.svh
// Assertion macros used by the checker file of the keyed quantity table.
// Depends on nothing; the including scope must provide clock and reset.
`ifndef KEYED_QUANTITY_TABLE_MACROS_SVH
`define KEYED_QUANTITY_TABLE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KQT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KQT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/kqt_pkg.sv
// Shared constants, status codes and the cell command type of the keyed quantity table.
// Depends on nothing; the design and checker files refer to it by scoped names.
`default_nettype none

package kqt_pkg;

   localparam int SLOTS = 16;
   localparam int KEY_BITS = 32;
   localparam int QTY_BITS = 16;
   localparam int IDX_BITS = $clog2(SLOTS);
   localparam int CNT_BITS = $clog2(SLOTS + 1);

   // Fixed widths of the port fields.
   localparam int OUT_IDX_BITS = 4;
   localparam int OUT_CNT_BITS = 5;
   localparam int LIMIT_BITS = 5;
   localparam int STATUS_BITS = 3;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_MERGED = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_INSERTED = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_REDUCED = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_DELETED = 3'd4;
   localparam logic [STATUS_BITS-1:0] STATUS_MISSING = 3'd5;

   // What one cell does at the next clock edge.
   typedef struct packed {
      logic shift;   // take the neighbor's key and quantity
      logic load;    // take the request key and amount as a new entry
      logic update;  // take the adjusted quantity
   } cell_cmd_type;

endpackage

`default_nettype wire

FILE: hdl/kqt_cell.sv
// One slot of the keyed quantity table: key and quantity registers, key compare,
// and the saturating add and clamping subtract. Depends on kqt_pkg.
`default_nettype none

module kqt_cell (
   input  wire logic                          clock,
   input  wire kqt_pkg::cell_cmd_type         cmd,
   input  wire logic                          op,
   input  wire logic [kqt_pkg::KEY_BITS-1:0]  req_key,
   input  wire logic [kqt_pkg::QTY_BITS-1:0]  req_amount,
   input  wire logic [kqt_pkg::KEY_BITS-1:0]  nbr_key,
   input  wire logic [kqt_pkg::QTY_BITS-1:0]  nbr_qty,
   output logic      [kqt_pkg::KEY_BITS-1:0]  key,
   output logic      [kqt_pkg::QTY_BITS-1:0]  qty,
   output logic      [kqt_pkg::QTY_BITS-1:0]  qty_new,
   output logic                               match
);

   logic [kqt_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [kqt_pkg::QTY_BITS-1:0] qty_ff, qty_in;
   logic [kqt_pkg::QTY_BITS:0]   sum;

   assign key = key_ff;
   assign qty = qty_ff;
   assign match = (key_ff == req_key);

   // The carry out of the add means the quantity saturates.
   assign sum = {1'b0, qty_ff} + {1'b0, req_amount};

   always_comb begin
      if (op == kqt_pkg::OP_ADD) begin
         qty_new = sum[kqt_pkg::QTY_BITS] ? '1 : sum[kqt_pkg::QTY_BITS-1:0];
      end else begin
         qty_new = (req_amount >= qty_ff) ? '0 : (qty_ff - req_amount);
      end
   end

   always_comb begin
      priority if (cmd.shift) begin
         key_in = nbr_key;
         qty_in = nbr_qty;
      end else if (cmd.load) begin
         key_in = req_key;
         qty_in = req_amount;
      end else if (cmd.update) begin
         key_in = key_ff;
         qty_in = qty_new;
      end else begin
         key_in = key_ff;
         qty_in = qty_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      qty_ff <= qty_in;
   end

endmodule

`default_nettype wire

FILE: hdl/keyed_quantity_table.sv
// Keyed quantity table top level: request register, row of slot cells, result register.
// An accepted request is held in the request register until the result register is free or being emptied.
// Throughput: one request per cycle while the result side takes results; the cells compare
// all slots at once and move the tail one slot on a deletion. Depends on kqt_pkg, kqt_cell.
// Reset (synchronous, active high) empties the table, clears both valid flags and sets
// the entry limit to 16; slot contents are not cleared and are never read before written.
`default_nettype none

module keyed_quantity_table (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel.
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_opcode,
   input  wire logic [kqt_pkg::KEY_BITS-1:0]      req_item_key,
   input  wire logic [kqt_pkg::QTY_BITS-1:0]      req_amount,
   // Result channel.
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [kqt_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic      [kqt_pkg::OUT_IDX_BITS-1:0]  rsp_slot_index,
   output logic      [kqt_pkg::QTY_BITS-1:0]      rsp_quantity_after,
   output logic      [kqt_pkg::OUT_CNT_BITS-1:0]  rsp_entry_count,
   // Configuration write channel for the entry limit.
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [kqt_pkg::LIMIT_BITS-1:0]    csr_max_items
);

   // The request register holds one request while the cells work on it.
   logic                          busy_ff, busy_in;
   logic                          op_ff;
   logic [kqt_pkg::KEY_BITS-1:0]  key_ff;
   logic [kqt_pkg::QTY_BITS-1:0]  amount_ff;

   logic [kqt_pkg::CNT_BITS-1:0]   count_ff, count_in;
   logic [kqt_pkg::LIMIT_BITS-1:0] max_items_ff, max_items_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [kqt_pkg::STATUS_BITS-1:0]       status_ff, status_in;
   logic [kqt_pkg::OUT_IDX_BITS-1:0]      slot_ff, slot_in;
   logic [kqt_pkg::QTY_BITS-1:0]          qty_after_ff, qty_after_in;
   logic [kqt_pkg::OUT_CNT_BITS-1:0]      entries_ff, entries_in;

   // Per-cell signals.
   kqt_pkg::cell_cmd_type         cmd [kqt_pkg::SLOTS];
   logic [kqt_pkg::KEY_BITS-1:0]  cell_key [kqt_pkg::SLOTS];
   logic [kqt_pkg::QTY_BITS-1:0]  cell_qty [kqt_pkg::SLOTS];
   logic [kqt_pkg::QTY_BITS-1:0]  cell_qty_new [kqt_pkg::SLOTS];
   logic [kqt_pkg::SLOTS-1:0]     cell_match;
   logic [kqt_pkg::SLOTS-1:0]     occupied;
   logic [kqt_pkg::SLOTS-1:0]     hit;

   logic                          accept;
   logic                          finish;
   logic                          hit_any;
   logic [kqt_pkg::IDX_BITS-1:0]  pos;
   logic [kqt_pkg::IDX_BITS-1:0]  tail;
   logic [kqt_pkg::QTY_BITS-1:0]  pos_qty_new;
   logic                          full;
   logic                          do_insert;
   logic                          do_update;
   logic                          do_delete;

   // A held request finishes once the result register is free or being emptied.
   // A new request can then enter at the same edge, so requests stream one per cycle while results are taken.
   // Neither the request channel nor the limit register takes anything while reset is held.
   assign finish = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!busy_ff || finish);
   assign accept = req_valid && req_ready;
   assign csr_ready = !reset;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_quantity_after = qty_after_ff;
   assign rsp_entry_count = entries_ff;

   // The row of cells. Each cell sees its upper neighbor so that a deletion closes the
   // gap in one step; the last cell has no neighbor and simply keeps its own contents.
   for (genvar i = 0; i < kqt_pkg::SLOTS; i++) begin : g_cell
      logic [kqt_pkg::KEY_BITS-1:0] nbr_key;
      logic [kqt_pkg::QTY_BITS-1:0] nbr_qty;

      if (i + 1 < kqt_pkg::SLOTS) begin : g_mid
         assign nbr_key = cell_key[i+1];
         assign nbr_qty = cell_qty[i+1];
      end else begin : g_last
         assign nbr_key = cell_key[i];
         assign nbr_qty = cell_qty[i];
      end

      kqt_cell u_cell (
         .clock      (clock),
         .cmd        (cmd[i]),
         .op         (op_ff),
         .req_key    (key_ff),
         .req_amount (amount_ff),
         .nbr_key    (nbr_key),
         .nbr_qty    (nbr_qty),
         .key        (cell_key[i]),
         .qty        (cell_qty[i]),
         .qty_new    (cell_qty_new[i]),
         .match      (cell_match[i])
      );

      // Only slots below the fill count hold entries; the rest are never trusted.
      assign occupied[i] = (i < int'(count_ff));
      assign hit[i] = cell_match[i] && occupied[i];
   end

   // Keys are unique among held entries, but the lowest hit is taken anyway.
   always_comb begin
      pos = '0;
      for (int i = kqt_pkg::SLOTS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            pos = kqt_pkg::IDX_BITS'(i);
         end
      end
   end

   assign hit_any = |hit;
   assign pos_qty_new = cell_qty_new[pos];
   assign tail = kqt_pkg::IDX_BITS'(count_ff);

   // A limit above the number of slots behaves like the number of slots.
   assign full = (int'(count_ff) >= int'(max_items_ff)) || (int'(count_ff) >= kqt_pkg::SLOTS);

   always_comb begin
      do_insert = 1'b0;
      do_update = 1'b0;
      do_delete = 1'b0;
      status_in = kqt_pkg::STATUS_MISSING;
      slot_in = '0;
      qty_after_in = '0;
      count_in = count_ff;

      if (op_ff == kqt_pkg::OP_ADD) begin
         priority if (hit_any) begin
            do_update = 1'b1;
            status_in = kqt_pkg::STATUS_MERGED;
            slot_in = kqt_pkg::OUT_IDX_BITS'(pos);
            qty_after_in = pos_qty_new;
         end else if (full) begin
            status_in = kqt_pkg::STATUS_FULL;
         end else begin
            do_insert = 1'b1;
            status_in = kqt_pkg::STATUS_INSERTED;
            slot_in = kqt_pkg::OUT_IDX_BITS'(count_ff);
            qty_after_in = amount_ff;
            count_in = count_ff + kqt_pkg::CNT_BITS'(1);
         end
      end else begin
         priority if (!hit_any) begin
            status_in = kqt_pkg::STATUS_MISSING;
         end else if (pos_qty_new == '0) begin
            // The entry runs out: it is removed and everything above it moves down.
            do_delete = 1'b1;
            status_in = kqt_pkg::STATUS_DELETED;
            slot_in = kqt_pkg::OUT_IDX_BITS'(pos);
            count_in = count_ff - kqt_pkg::CNT_BITS'(1);
         end else begin
            do_update = 1'b1;
            status_in = kqt_pkg::STATUS_REDUCED;
            slot_in = kqt_pkg::OUT_IDX_BITS'(pos);
            qty_after_in = pos_qty_new;
         end
      end

      entries_in = kqt_pkg::OUT_CNT_BITS'(count_in);
   end

   // Cell commands take effect only at the edge at which the request finishes.
   always_comb begin
      for (int i = 0; i < kqt_pkg::SLOTS; i++) begin
         cmd[i].shift = finish && do_delete && (i >= int'(pos));
         cmd[i].load = finish && do_insert && (i == int'(tail));
         cmd[i].update = finish && do_update && (i == int'(pos));
      end
   end

   always_comb begin
      busy_in = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      max_items_in = max_items_ff;
      if (finish) begin
         busy_in = 1'b0;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
      if (csr_valid && csr_ready) begin
         max_items_in = csr_max_items;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         max_items_ff <= kqt_pkg::LIMIT_RESET;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         max_items_ff <= max_items_in;
         if (finish) begin
            count_ff <= count_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_opcode;
         key_ff <= req_item_key;
         amount_ff <= req_amount;
      end
      if (finish) begin
         status_ff <= status_in;
         slot_ff <= slot_in;
         qty_after_ff <= qty_after_in;
         entries_ff <= entries_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/kqt_checker.sv
// Port-level checks of the keyed quantity table, bound to its top level.
// Depends on kqt_pkg and keyed_quantity_table_macros.svh.
`default_nettype none

`include "keyed_quantity_table_macros.svh"

module kqt_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [kqt_pkg::STATUS_BITS-1:0]   rsp_status,
   input wire logic [kqt_pkg::OUT_IDX_BITS-1:0]  rsp_slot_index,
   input wire logic [kqt_pkg::QTY_BITS-1:0]      rsp_quantity_after,
   input wire logic [kqt_pkg::OUT_CNT_BITS-1:0]  rsp_entry_count
);

   `KQT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_quantity_after) && $stable(rsp_entry_count), "result changed while stalled")
   `KQT_ASSERT_NOW(a_count_bound, rsp_valid, int'(rsp_entry_count) <= kqt_pkg::SLOTS, "entry count above slot count")
   `KQT_ASSERT_NOW(a_full_blank, rsp_valid && rsp_status == kqt_pkg::STATUS_FULL, rsp_slot_index == '0 && rsp_quantity_after == '0, "refused request reports a slot")
   `KQT_ASSERT_NOW(a_delete_zero, rsp_valid && rsp_status == kqt_pkg::STATUS_DELETED, rsp_quantity_after == '0, "deleted entry reports a quantity")
   `KQT_ASSERT_NOW(a_insert_count, rsp_valid && rsp_status == kqt_pkg::STATUS_INSERTED, int'(rsp_entry_count) == int'(rsp_slot_index) + 1, "inserted entry not at the end")

endmodule

bind keyed_quantity_table kqt_checker u_kqt_checker (.*);

`default_nettype wire
